>>> sv/fodm_pkg.sv
`default_nettype none

package fodm_pkg;

  // Heading resolution: only the top ANGLE_BITS bits of the heading are used.
  localparam int ANGLE_BITS = 16;
  localparam int FRAC_SHIFT = ANGLE_BITS - 7;
  localparam int PHASE_W    = ANGLE_BITS - 1;
  localparam int SINE_PTS   = 33;
  localparam int SINE_IDX_W = 6;

  // Quarter-wave sine points in Q1.15; the last point is saturated.
  localparam logic [15:0] SINE_Q15 [SINE_PTS] = '{
    16'd0,     16'd1608,  16'd3212,  16'd4808,  16'd6393,  16'd7962,  16'd9512,  16'd11039,
    16'd12540, 16'd14010, 16'd15447, 16'd16846, 16'd18205, 16'd19520, 16'd20788, 16'd22006,
    16'd23170, 16'd24279, 16'd25330, 16'd26320, 16'd27246, 16'd28106, 16'd28899, 16'd29622,
    16'd30274, 16'd30853, 16'd31357, 16'd31786, 16'd32138, 16'd32413, 16'd32610, 16'd32729,
    16'd32767
  };

  // Speed scale codes; the spare code acts as full speed.
  localparam logic [1:0] SCALE_0P3 = 2'd0;
  localparam logic [1:0] SCALE_0P5 = 2'd1;
  localparam logic [1:0] SCALE_1P0 = 2'd2;

  typedef logic signed [7:0] stick_t;
  typedef logic        [7:0] trig_t;
  typedef logic       [15:0] heading_t;
  typedef logic        [1:0] scale_t;
  typedef logic signed [9:0] motor_t;

endpackage

`default_nettype wire

>>> sv/fodm_ifs.sv
`default_nettype none

interface fodm_in_if;
  logic               valid;
  logic               ready;
  fodm_pkg::stick_t   stick_x;
  fodm_pkg::stick_t   stick_y;
  fodm_pkg::trig_t    trigger_right;
  fodm_pkg::trig_t    trigger_left;
  fodm_pkg::heading_t heading;
  fodm_pkg::scale_t   speed_scale;

  modport source (output valid, stick_x, stick_y, trigger_right, trigger_left, heading,
                  speed_scale, input ready);
  modport sink   (input valid, stick_x, stick_y, trigger_right, trigger_left, heading,
                  speed_scale, output ready);
endinterface

interface fodm_out_if;
  logic             valid;
  logic             ready;
  fodm_pkg::motor_t motor_bottom;
  fodm_pkg::motor_t motor_down;
  fodm_pkg::motor_t motor_up;
  fodm_pkg::motor_t motor_top;

  modport source (output valid, motor_bottom, motor_down, motor_up, motor_top, input ready);
  modport sink   (input valid, motor_bottom, motor_down, motor_up, motor_top, output ready);
endinterface

`default_nettype wire

>>> sv/field_oriented_omni_drive_mixer_unit.sv
// Field-oriented mixer for a four-wheel omni drive.
// in_ch carries one control sample per beat: stick x/y, both triggers, gyro heading
// and a speed-scale code. out_ch carries one beat per sample with the four motor
// commands (bottom, down, up, top), 10-bit two's complement.
// Both channels use valid/ready; a beat moves when both are high.
// Throughput: one sample per clock while out_ch does not stall; the eight register
// stages (sine lookup, interpolation, stick products, wheel sums, scale product,
// numerator, reciprocal product, correction/output) each hold one sample.
// Stall: the whole pipe advances together; when the output beat is held by the
// receiver, in_ch.ready drops in the same cycle and every stage holds its data.
// Bubbles travel as cleared valid bits, so nothing is lost or repeated.
// Reset (rst_n low, synchronous): all valid bits clear; the pipe is empty and
// ready right after. Data registers are not reset.
`default_nettype none

module field_oriented_omni_drive_mixer_unit (
  input  wire        clk,
  input  wire        rst_n,
  fodm_in_if.sink    in_ch,
  fodm_out_if.source out_ch
);

  localparam int AB = fodm_pkg::ANGLE_BITS;
  localparam int FS = fodm_pkg::FRAC_SHIFT;
  localparam int PW = fodm_pkg::PHASE_W;
  localparam int QW = AB - 2;
  localparam int IW = fodm_pkg::SINE_IDX_W;
  localparam int NSTG = 8;

  localparam logic [AB-1:0] EIGHTH  = AB'(1 << (AB - 3));
  localparam logic [PW-1:0] QUARTER = PW'(1 << (AB - 2));

  localparam logic [1:0] QUAD_I   = 2'd0;
  localparam logic [1:0] QUAD_II  = 2'd1;
  localparam logic [1:0] QUAD_III = 2'd2;

  // Reciprocal of 125 in Q22; one correction step finishes the quotient.
  localparam logic [15:0] RECIP_125 = 16'd33554;
  localparam logic  [6:0] DIV_125   = 7'd125;
  localparam logic [16:0] TWO_DIV   = 17'd250;

  // Lanes of the last stages: 0 bottom, 1 down, 2 up, 3 top.
  localparam int LANES = 4;

  // ---------------------------------------------------------------------------
  // Pipe control: one enable for all stages
  // ---------------------------------------------------------------------------
  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] vld_nxt;
  logic            pipe_en;

  assign pipe_en     = !vld_r[NSTG-1] || out_ch.ready;
  assign in_ch.ready = pipe_en;
  assign vld_nxt     = pipe_en ? {vld_r[NSTG-2:0], in_ch.valid} : vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage A: heading + 45 degrees, table lookups for both quarter phases
  // ---------------------------------------------------------------------------
  logic [AB-1:0] ang;
  logic [PW-1:0] phase [2];
  logic [IW-1:0] tidx  [2];
  logic [IW-1:0] tlo   [2];
  logic [IW-1:0] thi   [2];
  logic [15:0]   tdiff [2];

  logic [14:0]        base_a_r [2];
  logic [10:0]        diff_a_r [2];
  logic [FS-1:0]      frac_a_r [2];
  logic [1:0]         quad_a_r;
  logic signed [7:0]  x_a_r;
  logic signed [7:0]  y_a_r;
  logic signed [8:0]  d_a_r;
  logic [1:0]         code_a_r;

  always_comb begin
    ang      = in_ch.heading[15 -: AB] + EIGHTH;
    phase[0] = {1'b0, ang[QW-1:0]};
    phase[1] = QUARTER - phase[0];
    for (int k = 0; k < 2; k++) begin
      tidx[k]  = phase[k][PW-1:FS];
      // at the quarter point the fraction is zero, so the slope is a don't-care
      tlo[k]   = {1'b0, tidx[k][IW-2:0]};
      thi[k]   = tlo[k] + IW'(1);
      tdiff[k] = fodm_pkg::SINE_Q15[thi[k]] - fodm_pkg::SINE_Q15[tlo[k]];
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      for (int k = 0; k < 2; k++) begin
        base_a_r[k] <= fodm_pkg::SINE_Q15[tidx[k]][14:0];
        diff_a_r[k] <= tdiff[k][10:0];
        frac_a_r[k] <= phase[k][FS-1:0];
      end
      quad_a_r <= ang[AB-1 -: 2];
      x_a_r    <= in_ch.stick_x;
      y_a_r    <= in_ch.stick_y;
      d_a_r    <= $signed({1'b0, in_ch.trigger_right}) - $signed({1'b0, in_ch.trigger_left});
      code_a_r <= in_ch.speed_scale;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage B: interpolate, fold quadrant into sin/cos; rotation term
  // ---------------------------------------------------------------------------
  logic [10+FS:0]      ip_prod [2];
  logic [14:0]         qsin    [2];
  logic signed [15:0]  s_nxt;
  logic signed [15:0]  c_nxt;
  logic [5:0]          k5m_nxt;
  logic [20:0]         tcoef;

  logic signed [15:0]  s_b_r;
  logic signed [15:0]  c_b_r;
  logic signed [7:0]   x_b_r;
  logic signed [7:0]   y_b_r;
  logic signed [29:0]  t_b_r;
  logic [5:0]          k5m_b_r;

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      ip_prod[k] = diff_a_r[k] * frac_a_r[k];
      qsin[k]    = base_a_r[k] + {4'd0, ip_prod[k][10+FS:FS]};
    end
    case (quad_a_r)
      QUAD_I: begin
        s_nxt = $signed({1'b0, qsin[0]});
        c_nxt = $signed({1'b0, qsin[1]});
      end
      QUAD_II: begin
        s_nxt = $signed({1'b0, qsin[1]});
        c_nxt = -$signed({1'b0, qsin[0]});
      end
      QUAD_III: begin
        s_nxt = -$signed({1'b0, qsin[0]});
        c_nxt = -$signed({1'b0, qsin[1]});
      end
      default: begin
        s_nxt = -$signed({1'b0, qsin[1]});
        c_nxt = $signed({1'b0, qsin[0]});
      end
    endcase
    // wheel numerator, reduced by 16: -5*m*p + 98304*(15-m)*d, scale = 0.1*m
    case (code_a_r)
      fodm_pkg::SCALE_0P3: begin
        k5m_nxt = 6'd15;
        tcoef   = 21'd1179648;
      end
      fodm_pkg::SCALE_0P5: begin
        k5m_nxt = 6'd25;
        tcoef   = 21'd983040;
      end
      default: begin
        k5m_nxt = 6'd50;
        tcoef   = 21'd491520;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s_b_r   <= s_nxt;
      c_b_r   <= c_nxt;
      x_b_r   <= x_a_r;
      y_b_r   <= y_a_r;
      t_b_r   <= d_a_r * $signed({1'b0, tcoef});
      k5m_b_r <= k5m_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage C: stick products
  // ---------------------------------------------------------------------------
  logic signed [23:0] sx_c_r;
  logic signed [23:0] cy_c_r;
  logic signed [23:0] cx_c_r;
  logic signed [23:0] sy_c_r;
  logic signed [29:0] t_c_r;
  logic [5:0]         k5m_c_r;

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      sx_c_r  <= s_b_r * x_b_r;
      cy_c_r  <= c_b_r * y_b_r;
      cx_c_r  <= c_b_r * x_b_r;
      sy_c_r  <= s_b_r * y_b_r;
      t_c_r   <= t_b_r;
      k5m_c_r <= k5m_b_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage D: rotated wheel terms p0 = -s*x + c*y, p1 = -c*x - s*y
  // ---------------------------------------------------------------------------
  logic signed [24:0] p0_d_r;
  logic signed [24:0] p1_d_r;
  logic signed [29:0] t_d_r;
  logic [5:0]         k5m_d_r;

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      p0_d_r  <= 25'(cy_c_r) - 25'(sx_c_r);
      p1_d_r  <= -25'(cx_c_r) - 25'(sy_c_r);
      t_d_r   <= t_c_r;
      k5m_d_r <= k5m_c_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage E: speed scale
  // ---------------------------------------------------------------------------
  logic signed [31:0] q0_e_r;
  logic signed [31:0] q1_e_r;
  logic signed [29:0] t_e_r;

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      q0_e_r <= p0_d_r * $signed({1'b0, k5m_d_r});
      q1_e_r <= p1_d_r * $signed({1'b0, k5m_d_r});
      t_e_r  <= t_d_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage F: four numerators, sign/magnitude, drop the 2^14 factor of 2048000
  // ---------------------------------------------------------------------------
  logic signed [32:0] num [LANES];
  logic [32:0]        mag [LANES];
  logic [15:0]        b_f_r   [LANES];
  logic               neg_f_r [LANES];

  always_comb begin
    num[0] = 33'(t_e_r) - 33'(q1_e_r);
    num[1] = 33'(t_e_r) + 33'(q0_e_r);
    num[2] = 33'(t_e_r) - 33'(q0_e_r);
    num[3] = 33'(t_e_r) + 33'(q1_e_r);
    for (int k = 0; k < LANES; k++) begin
      mag[k] = num[k][32] ? 33'(-num[k]) : 33'(num[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      for (int k = 0; k < LANES; k++) begin
        b_f_r[k]   <= mag[k][29:14];
        neg_f_r[k] <= num[k][32];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage G: estimate b / 125 by reciprocal
  // ---------------------------------------------------------------------------
  logic [31:0] rprod [LANES];
  logic [9:0]  q_g_r   [LANES];
  logic [15:0] b_g_r   [LANES];
  logic        neg_g_r [LANES];

  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      rprod[k] = b_f_r[k] * RECIP_125;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      for (int k = 0; k < LANES; k++) begin
        q_g_r[k]   <= rprod[k][31:22];
        b_g_r[k]   <= b_f_r[k];
        neg_g_r[k] <= neg_f_r[k];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage H: correct the quotient by one, restore sign, clamp, output register
  // ---------------------------------------------------------------------------
  logic [16:0]        rem  [LANES];
  logic [10:0]        quo  [LANES];
  logic signed [10:0] sval [LANES];
  logic [9:0]         mot_nxt [LANES];
  logic               rem_ok;
  logic [9:0]         mot_r [LANES];

  always_comb begin
    rem_ok = 1'b1;
    for (int k = 0; k < LANES; k++) begin
      rem[k]  = 17'(b_g_r[k]) - q_g_r[k] * DIV_125;
      quo[k]  = 11'(q_g_r[k]) + 11'(rem[k] >= 17'(DIV_125));
      sval[k] = neg_g_r[k] ? -$signed(quo[k]) : $signed(quo[k]);
      if (sval[k] > 11'sd511) begin
        mot_nxt[k] = 10'h1FF;
      end else if (sval[k] < -11'sd512) begin
        mot_nxt[k] = 10'h200;
      end else begin
        mot_nxt[k] = sval[k][9:0];
      end
      rem_ok = rem_ok && (rem[k] < TWO_DIV);
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      for (int k = 0; k < LANES; k++) begin
        mot_r[k] <= mot_nxt[k];
      end
    end
  end

  assign out_ch.valid        = vld_r[NSTG-1];
  assign out_ch.motor_bottom = $signed(mot_r[0]);
  assign out_ch.motor_down   = $signed(mot_r[1]);
  assign out_ch.motor_up     = $signed(mot_r[2]);
  assign out_ch.motor_top    = $signed(mot_r[3]);

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !pipe_en |=> $stable(vld_r))
    else $error("pipe valid bits moved during a stall");

  a_beat_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> vld_r[0])
    else $error("accepted input beat did not enter the pipe");

  a_num_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[5] |-> (b_f_r[0][15] || b_f_r[1][15] || b_f_r[2][15] || b_f_r[3][15]) == 1'b0)
    else $error("wheel numerator exceeds its range");

  a_quot_fix: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[6] |-> rem_ok)
    else $error("reciprocal quotient off by more than one");

endmodule

`default_nettype wire

>>> tb/sv/tb_field_oriented_omni_drive_mixer_unit.sv
module tb_field_oriented_omni_drive_mixer_unit;
  import fodm_pkg::*;

  // One control sample as it goes onto in_ch.
  typedef struct packed {
    stick_t   stick_x;
    stick_t   stick_y;
    trig_t    trigger_right;
    trig_t    trigger_left;
    heading_t heading;
    scale_t   speed_scale;
  } drive_sample_t;

  // The four motor commands of one out_ch beat.
  typedef struct packed {
    motor_t bottom;
    motor_t down;
    motor_t up;
    motor_t top;
  } motor_cmds_t;

  localparam int     RANDOM_SAMPLES = 850;
  localparam int     IDLE_PCT       = 23;
  localparam int     DRAIN_CYCLES   = 16;
  localparam longint QUARTER_STEPS  = longint'(1) << (ANGLE_BITS - 2);
  localparam longint ANGLE_MASK     = (longint'(1) << ANGLE_BITS) - 1;
  localparam longint FRAC_MASK      = (longint'(1) << FRAC_SHIFT) - 1;
  localparam longint CMD_DIVISOR    = 64'sd32768000;

  logic clk = 1'b0;
  logic rst_n;

  fodm_in_if  in_ch ();
  fodm_out_if out_ch ();

  field_oriented_omni_drive_mixer_unit u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 0;
  end

  drive_sample_t pending_samples[$];   // samples not yet put on the bus
  motor_cmds_t   expected_cmds[$];     // predicted beats, oldest first
  drive_sample_t on_bus;               // sample currently offered on in_ch
  drive_sample_t next_sample;
  motor_cmds_t   seen_cmds;
  motor_cmds_t   want_cmds;
  int            beats_in   = 0;
  int            error_count = 0;
  logic          calm;

  // Both sides stop idling for a stretch of the run so back-to-back beats
  // get exercised with the pipe running full.
  assign calm = (beats_in >= 350) && (beats_in < 550);

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Sine of p steps into the first quadrant, p in 0..QUARTER_STEPS. Table points
  // are linearly interpolated; the top point stands alone.
  function automatic longint quarter_wave(longint p);
    longint idx;
    longint frac;
    longint lo;
    longint hi;
    idx = p >> FRAC_SHIFT;
    if (idx >= SINE_PTS - 1) begin
      return longint'(SINE_Q15[SINE_PTS-1]);
    end
    frac = p & FRAC_MASK;
    lo   = longint'(SINE_Q15[idx]);
    hi   = longint'(SINE_Q15[idx+1]);
    return lo + (((hi - lo) * frac) >> FRAC_SHIFT);
  endfunction

  // Sine of a binary angle: mirror the odd quadrants, negate the lower half-turn.
  function automatic longint bam_sine(longint a);
    longint quad;
    longint q;
    a    = a & ANGLE_MASK;
    quad = a >> (ANGLE_BITS - 2);
    q    = a & (QUARTER_STEPS - 1);
    case (quad)
      0: begin
        return quarter_wave(q);
      end
      1: begin
        return quarter_wave(QUARTER_STEPS - q);
      end
      2: begin
        return -quarter_wave(q);
      end
      default: begin
        return -quarter_wave(QUARTER_STEPS - q);
      end
    endcase
  endfunction

  // -v * 0.8 * scale + (0.72 - 0.48 * scale) * rotation in exact integers, truncated
  // toward zero, then clamped to the command range.
  function automatic motor_t wheel_cmd(longint p, longint d, longint g);
    longint num;
    longint val;
    num = -10 * g * p + 32768 * d * (720 - 6 * g);
    val = num / CMD_DIVISOR;
    if (val > 511) begin
      val = 511;
    end
    if (val < -512) begin
      val = -512;
    end
    return motor_t'(val);
  endfunction

  function automatic motor_cmds_t mix_wheels(drive_sample_t smp);
    motor_cmds_t cmds;
    longint x;
    longint y;
    longint d;
    longint a;
    longint s;
    longint c;
    longint g;
    longint p0;
    longint p1;
    x = longint'(smp.stick_x);
    y = longint'(smp.stick_y);
    d = longint'(smp.trigger_right) - longint'(smp.trigger_left);
    // Field orientation: rotate by heading plus an eighth of a turn.
    a = ((longint'(smp.heading) >> (16 - ANGLE_BITS)) + (longint'(1) << (ANGLE_BITS - 3)))
        & ANGLE_MASK;
    s = bam_sine(a);
    c = bam_sine(a + QUARTER_STEPS);
    case (smp.speed_scale)
      SCALE_0P3: begin
        g = 24;
      end
      SCALE_0P5: begin
        g = 40;
      end
      default: begin
        g = 80;   // full speed, spare code included
      end
    endcase
    p0 = -s * x + c * y;
    p1 = -c * x - s * y;
    cmds.bottom = wheel_cmd(p1, d, g);
    cmds.down   = wheel_cmd(-p0, d, g);
    cmds.up     = wheel_cmd(p0, d, g);
    cmds.top    = wheel_cmd(-p1, d, g);
    return cmds;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  task automatic add_sample(int x, int y, int tr, int tl, int hd, int sc);
    drive_sample_t smp;
    smp.stick_x       = stick_t'(x);
    smp.stick_y       = stick_t'(y);
    smp.trigger_right = trig_t'(tr);
    smp.trigger_left  = trig_t'(tl);
    smp.heading       = heading_t'(hd);
    smp.speed_scale   = scale_t'(sc);
    pending_samples.push_back(smp);
  endtask

  function automatic int pick_stick();
    case ($urandom_range(9))
      0: begin
        return -128;
      end
      1: begin
        return 127;
      end
      default: begin
        return $urandom_range(255) - 128;
      end
    endcase
  endfunction

  function automatic int pick_heading();
    // Mostly uniform; sometimes land right around a quadrant or table edge.
    if ($urandom_range(9) == 0) begin
      return ($urandom_range(3) * 16'h4000 + 16'h2000 + $urandom_range(4) - 2) & 16'hFFFF;
    end
    return $urandom_range(16'hFFFF);
  endfunction

  task automatic fill_directed();
    add_sample(0, 0, 0, 0, 0, SCALE_0P3);
    // full stick and full triggers at the heading extremes
    add_sample(127, 127, 255, 0, 16'h0000, SCALE_1P0);
    add_sample(-128, -128, 0, 255, 16'hFFFF, SCALE_1P0);
    add_sample(127, -128, 255, 255, 16'h0000, SCALE_0P5);
    // rotated angle exactly on each quadrant boundary (saturated table top)
    add_sample(127, -128, 255, 255, 16'h2000, SCALE_0P5);
    add_sample(-128, 127, 0, 0, 16'h6000, SCALE_0P3);
    add_sample(-128, 127, 17, 200, 16'hA000, SCALE_1P0);
    add_sample(100, -37, 200, 17, 16'hE000, SCALE_0P3);
    // neighbors of a boundary exercise interpolation on both sides
    add_sample(-128, -128, 128, 127, 16'h1FFF, SCALE_1P0);
    add_sample(-128, -128, 127, 128, 16'h2001, SCALE_1P0);
    add_sample(1, -1, 1, 0, 16'h5FFF, SCALE_0P5);
    // each speed code under the largest demand, the spare code too
    add_sample(-128, -128, 255, 0, 16'h1234, SCALE_0P3);
    add_sample(-128, -128, 255, 0, 16'h1234, SCALE_0P5);
    add_sample(-128, -128, 255, 0, 16'h1234, SCALE_1P0);
    add_sample(-128, -128, 255, 0, 16'h1234, 3);
    add_sample(127, 127, 0, 255, 16'hC000, 3);
    // pure rotation, no stick
    add_sample(0, 0, 255, 0, 16'h8000, SCALE_1P0);
    add_sample(0, 0, 0, 255, 16'h4000, SCALE_0P3);
  endtask

  task automatic fill_random();
    for (int i = 0; i < RANDOM_SAMPLES; i++) begin
      add_sample(pick_stick(), pick_stick(), $urandom_range(255), $urandom_range(255),
                 pick_heading(), $urandom_range(3));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offer the next sample when the bus slot is free, idle at random.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      // A beat moved: predict its commands now.
      if (in_ch.valid && in_ch.ready) begin
        expected_cmds.push_back(mix_wheels(on_bus));
        beats_in <= beats_in + 1;
      end
      // Hold the current beat while it is stalled; otherwise load or idle.
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_samples.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
          next_sample          = pending_samples.pop_front();
          on_bus              <= next_sample;
          in_ch.stick_x       <= next_sample.stick_x;
          in_ch.stick_y       <= next_sample.stick_y;
          in_ch.trigger_right <= next_sample.trigger_right;
          in_ch.trigger_left  <= next_sample.trigger_left;
          in_ch.heading       <= next_sample.heading;
          in_ch.speed_scale   <= next_sample.speed_scale;
          in_ch.valid         <= 1'b1;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver back-pressure: stall at random outside the calm stretch.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compare each result beat with the oldest prediction.
  // ---------------------------------------------------------------------------
  task automatic check_motor(string label, motor_t want, motor_t got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      seen_cmds.bottom = out_ch.motor_bottom;
      seen_cmds.down   = out_ch.motor_down;
      seen_cmds.up     = out_ch.motor_up;
      seen_cmds.top    = out_ch.motor_top;
      if (expected_cmds.size() == 0) begin
        $display("%0t: unexpected beat, expected none, actual %h", $time, seen_cmds);
        error_count++;
      end else begin
        want_cmds = expected_cmds.pop_front();
        check_motor("motor_bottom", want_cmds.bottom, seen_cmds.bottom);
        check_motor("motor_down", want_cmds.down, seen_cmds.down);
        check_motor("motor_up", want_cmds.up, seen_cmds.up);
        check_motor("motor_top", want_cmds.top, seen_cmds.top);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: reset, run all samples, drain, report.
  // ---------------------------------------------------------------------------
  initial begin
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.stick_x       = '0;
    in_ch.stick_y       = '0;
    in_ch.trigger_right = '0;
    in_ch.trigger_left  = '0;
    in_ch.heading       = '0;
    in_ch.speed_scale   = '0;
    out_ch.ready        = 1'b0;
    fill_directed();
    fill_random();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    // Wait for every sample to be taken and every prediction to be matched.
    do begin
      @(posedge clk);
    end while (pending_samples.size() != 0 || in_ch.valid || expected_cmds.size() != 0);
    // Let the pipe run on past its latency to catch any stray beat.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_field_oriented_omni_drive_mixer_unit: done, clean");
    end else begin
      $display("tb_field_oriented_omni_drive_mixer_unit: done, errors");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #(12 * 200000);
    $display("tb_field_oriented_omni_drive_mixer_unit: done, errors");
    $finish;
  end

endmodule
